/* src/nacs_pkg.sv */
// Shared constants and types for the nesting-aware comma splitter.
package nacs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned PIECE_W = 16;

    localparam logic [BYTE_W-1:0]  CH_LPAREN    = 8'h28;
    localparam logic [BYTE_W-1:0]  CH_RPAREN    = 8'h29;
    localparam logic [BYTE_W-1:0]  CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0]  CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0]  CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0]  CH_HASH      = 8'h23;
    localparam logic [BYTE_W-1:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0]  CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0]  CH_BACKSLASH = 8'h5C;

    localparam logic [PIECE_W-1:0] PIECE_MAX    = {PIECE_W{1'b1}};

    // One result beat as produced by the scanner.
    typedef struct packed {
        logic [BYTE_W-1:0]  byte_val;
        logic               split;
        logic [PIECE_W-1:0] piece;
        logic               done;
    } nacs_result_t;

endpackage

/* src/nesting_aware_comma_splitter.sv */
// Top level of the nesting-aware comma splitter: input register, scanner, result register.
//
// Usage:
//   Text channel (text_valid/text_ready) carries one list character per beat
//   in text_byte, with final_byte set on the last character of a list.
//   Result channel (result_valid/result_ready) returns exactly one beat per
//   text beat, in order: the byte itself (byte_out), is_split for a comma
//   that separates top-level pieces, the piece index (piece_number) and
//   list_done copied from final_byte.
//   Path: each byte passes through two register stages, the input hold
//   register and then the result register, before it reaches the result channel.
//   Throughput: one byte per cycle while result_ready is high. The scanner
//   state updates in the cycle a byte moves from the hold register into the
//   result register, so the next byte sees the updated depths and flags with no bubble.
//   Stall: when result_ready is low the result register holds its beat; the
//   hold register still takes one more byte, then text_ready drops until the
//   result beat drains.
//   Reset: rst_n clears both stages' valid flags and all scanner state
//   (depths, string/comment/backslash flags, piece index) to zero.
//   After a beat with final_byte set, all scanner state returns to zero.
module nesting_aware_comma_splitter
    import nacs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic               final_byte,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [BYTE_W-1:0]  byte_out,
    output logic               is_split,
    output logic [PIECE_W-1:0] piece_number,
    output logic               list_done
);

    logic              hold_valid_reg;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic              hold_final_reg;
    logic              result_valid_reg;
    nacs_result_t      result_reg;
    nacs_result_t      scan_result;
    logic              advance;

    // Move the held byte forward whenever the result register is free or draining.
    assign advance    = hold_valid_reg && (!result_valid_reg || result_ready);
    assign text_ready = !hold_valid_reg || advance;

    // Input hold register: take a beat whenever the slot is free or emptying.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (text_ready)
            hold_valid_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            hold_byte_reg  <= text_byte;
            hold_final_reg <= final_byte;
        end
    end

    nacs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .text_byte  (hold_byte_reg),
        .final_byte (hold_final_reg),
        .result     (scan_result)
    );

    // Result register: load on advance, drop valid once the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= scan_result;
    end

    assign result_valid = result_valid_reg;
    assign byte_out     = result_reg.byte_val;
    assign is_split     = result_reg.split;
    assign piece_number = result_reg.piece;
    assign list_done    = result_reg.done;

endmodule

/* src/nacs_scan.sv */
// Per-byte scanner: nesting, string, comment and piece state with its update logic.
module nacs_scan
    import nacs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              final_byte,
    output nacs_result_t      result
);

    logic [DEPTH_W-1:0] paren_depth_reg, paren_depth_next;
    logic [DEPTH_W-1:0] brace_depth_reg, brace_depth_next;
    logic               in_string_reg, in_string_next;
    logic               in_comment_reg, in_comment_next;
    logic               prior_bs_reg, prior_bs_next;
    logic [PIECE_W-1:0] piece_reg, piece_next;
    logic               active;
    logic               split;

    always_comb
    begin
        active           = !in_string_reg && !in_comment_reg;
        split            = 1'b0;
        paren_depth_next = paren_depth_reg;
        brace_depth_next = brace_depth_reg;
        in_string_next   = in_string_reg;
        in_comment_next  = in_comment_reg;
        piece_next       = piece_reg;
        prior_bs_next    = (text_byte == CH_BACKSLASH);

        unique case (text_byte)
            CH_LPAREN:
            begin
                if (active) paren_depth_next = paren_depth_reg + 1'b1;
            end
            CH_RPAREN:
            begin
                if (active) paren_depth_next = paren_depth_reg - 1'b1;
            end
            CH_LBRACE:
            begin
                if (active) brace_depth_next = brace_depth_reg + 1'b1;
            end
            CH_RBRACE:
            begin
                if (active) brace_depth_next = brace_depth_reg - 1'b1;
            end
            CH_QUOTE:
            begin
                // escaped quote inside a string does not close it
                if (!in_comment_reg && !(in_string_reg && prior_bs_reg))
                    in_string_next = !in_string_reg;
            end
            CH_HASH:
            begin
                if (!in_string_reg) in_comment_next = 1'b1;
            end
            CH_NEWLINE:
            begin
                in_string_next  = 1'b0;
                in_comment_next = 1'b0;
            end
            CH_COMMA:
            begin
                if (active && paren_depth_reg == '0 && brace_depth_reg == '0)
                begin
                    split = 1'b1;
                    if (piece_reg != PIECE_MAX) piece_next = piece_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // clear everything after the last byte of a list
        if (final_byte)
        begin
            paren_depth_next = '0;
            brace_depth_next = '0;
            in_string_next   = 1'b0;
            in_comment_next  = 1'b0;
            prior_bs_next    = 1'b0;
            piece_next       = '0;
        end

        result.byte_val = text_byte;
        result.split    = split;
        result.piece    = piece_reg;
        result.done     = final_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paren_depth_reg <= '0;
            brace_depth_reg <= '0;
            in_string_reg   <= 1'b0;
            in_comment_reg  <= 1'b0;
            prior_bs_reg    <= 1'b0;
            piece_reg       <= '0;
        end
        else if (step)
        begin
            paren_depth_reg <= paren_depth_next;
            brace_depth_reg <= brace_depth_next;
            in_string_reg   <= in_string_next;
            in_comment_reg  <= in_comment_next;
            prior_bs_reg    <= prior_bs_next;
            piece_reg       <= piece_next;
        end
    end

endmodule

/* src/nacs_checker.sv */
// Port-level checks for the nesting-aware comma splitter, bound to the top level.
module nacs_checker
    import nacs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               text_valid,
    input logic               text_ready,
    input logic [BYTE_W-1:0]  text_byte,
    input logic               final_byte,
    input logic               result_valid,
    input logic               result_ready,
    input logic [BYTE_W-1:0]  byte_out,
    input logic               is_split,
    input logic [PIECE_W-1:0] piece_number,
    input logic               list_done
);

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(byte_out) && $stable(is_split) && $stable(piece_number) &&
            $stable(list_done))
        else $error("result payload changed while stalled");

    // Only a comma can split a list.
    a_split_comma: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_split |-> byte_out == CH_COMMA)
        else $error("split flagged on a non-comma byte");

    // With the result channel empty, the block always takes input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> text_ready)
        else $error("input stalled with an empty result channel");

endmodule

bind nesting_aware_comma_splitter nacs_checker u_nacs_checker (.*);

/* tb/nacs_split_checker.sv */
// Checker for the comma splitter: predicts every result beat and compares it.
module nacs_split_checker
    import nacs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    input  logic               text_ready,
    input  logic [BYTE_W-1:0]  text_byte,
    input  logic               final_byte,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic [BYTE_W-1:0]  byte_out,
    input  logic               is_split,
    input  logic [PIECE_W-1:0] piece_number,
    input  logic               list_done,
    output int                 mismatches,
    output int                 bytes_in,
    output int                 bytes_out,
    output int                 splits_seen,
    output int                 lists_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [DEPTH_W-1:0] paren_lvl;
    logic [DEPTH_W-1:0] brace_lvl;
    logic               quoted;
    logic               commented;
    logic               escaped;
    logic [PIECE_W-1:0] piece_cnt;

    // Marks expected for bytes that went in and have not come out yet.
    nacs_result_t       pending_marks[$];

    function automatic void clear_scan();
        paren_lvl = '0;
        brace_lvl = '0;
        quoted    = 1'b0;
        commented = 1'b0;
        escaped   = 1'b0;
        piece_cnt = '0;
    endfunction

    // Advance the scan state by one byte and return the mark it gets.
    function automatic void scan_char(input logic [BYTE_W-1:0] c, input logic last,
                                      output nacs_result_t mark);
        logic live;
        live          = !quoted && !commented;
        mark.byte_val = c;
        mark.split    = 1'b0;
        mark.piece    = piece_cnt;
        mark.done     = last;
        case (c)
            CH_LPAREN:    if (live) paren_lvl = paren_lvl + 1'b1;
            CH_RPAREN:    if (live) paren_lvl = paren_lvl - 1'b1;
            CH_LBRACE:    if (live) brace_lvl = brace_lvl + 1'b1;
            CH_RBRACE:    if (live) brace_lvl = brace_lvl - 1'b1;
            CH_QUOTE:     if (!commented && !(quoted && escaped)) quoted = !quoted;
            CH_HASH:      if (!quoted) commented = 1'b1;
            CH_NEWLINE:
            begin
                quoted    = 1'b0;
                commented = 1'b0;
            end
            CH_COMMA:
            begin
                if (live && paren_lvl == '0 && brace_lvl == '0)
                begin
                    mark.split = 1'b1;
                    if (piece_cnt != PIECE_MAX) piece_cnt = piece_cnt + 1'b1;
                end
            end
            default: ;
        endcase
        escaped = (c == CH_BACKSLASH);
        if (last) clear_scan();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nacs_result_t want;
        nacs_result_t got;
        if (!rst_n)
        begin
            clear_scan();
            pending_marks.delete();
            mismatches      <= 0;
            bytes_in        <= 0;
            bytes_out       <= 0;
            splits_seen     <= 0;
            lists_closed    <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                got = {byte_out, is_split, piece_number, list_done};
                bytes_out <= bytes_out + 1;
                if (got.split === 1'b1) splits_seen <= splits_seen + 1;
                if (got.done === 1'b1) lists_closed <= lists_closed + 1;
                if (pending_marks.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display({"%0t: result beat with nothing expected: ",
                                  "byte=%h split=%b piece=%0d done=%b"},
                                 $realtime, got.byte_val, got.split, got.piece, got.done);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_marks.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"%0t: expected byte=%h split=%b piece=%0d done=%b, ",
                                      "got byte=%h split=%b piece=%0d done=%b"},
                                     $realtime, want.byte_val, want.split, want.piece,
                                     want.done, got.byte_val, got.split, got.piece,
                                     got.done);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (text_valid && text_ready)
            begin
                scan_char(text_byte, final_byte, want);
                pending_marks.insert(pending_marks.size(), want);
                bytes_in <= bytes_in + 1;
            end
        end
    end

endmodule

/* tb/nesting_aware_comma_splitter_tb.sv */
// Testbench top for the comma splitter: stimulus, receiver stalls, watchdog and verdict.
module nesting_aware_comma_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nacs_pkg::*;

    localparam int RANDOM_BEATS   = 800;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    // Receiver behaviors; each one runs for a random stretch of cycles.
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               text_valid   = 1'b0;
    logic               text_ready;
    logic [BYTE_W-1:0]  text_byte    = '0;
    logic               final_byte   = 1'b0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [BYTE_W-1:0]  byte_out;
    logic               is_split;
    logic [PIECE_W-1:0] piece_number;
    logic               list_done;

    int                 mismatches;
    int                 bytes_in;
    int                 bytes_out;
    int                 splits_seen;
    int                 lists_closed;

    // Sender bookkeeping.
    int                 hold_requests = 0;
    int                 burst_left    = 0;
    bit                 steady        = 1'b0;
    int                 beats_sent    = 0;

    nesting_aware_comma_splitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .byte_out     (byte_out),
        .is_split     (is_split),
        .piece_number (piece_number),
        .list_done    (list_done)
    );

    nacs_split_checker u_split_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .text_valid      (text_valid),
        .text_ready      (text_ready),
        .text_byte       (text_byte),
        .final_byte      (final_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .byte_out        (byte_out),
        .is_split        (is_split),
        .piece_number    (piece_number),
        .list_done       (list_done),
        .mismatches      (mismatches),
        .bytes_in        (bytes_in),
        .bytes_out       (bytes_out),
        .splits_seen     (splits_seen),
        .lists_closed    (lists_closed)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Offer one text beat and hold it until the block takes it. The sender runs
    // in bursts; between bursts it drops valid for a random gap, unless the
    // current phase asks for a steady stream.
    task automatic offer(input logic [BYTE_W-1:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 20);
            if (!steady)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
                text_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        text_valid <= 1'b1;
        text_byte  <= c;
        final_byte <= last;
        do @(posedge clk); while (!text_ready);
        beats_sent++;
    endtask

    // Send a whole list; its last character carries final_byte.
    task automatic send_list(input string s);
        for (int k = 0; k < s.len(); k++)
            offer(s[k], k == s.len() - 1);
    endtask

    // Drop valid and hold off until every byte sent has come back out.
    task automatic wait_all_back();
        text_valid <= 1'b0;
        do @(posedge clk); while (bytes_in != bytes_out);
    endtask

    // Draw the next random character. Letters and commas dominate so that
    // pieces form; brackets, quotes, escapes, comments and newlines are mixed
    // in, plus a share of arbitrary bytes. Closing brackets mostly match an
    // opening one, but some arrive unbalanced on purpose.
    function automatic logic [BYTE_W-1:0] pick_char(input int open_lvl);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 28) return BYTE_W'("a" + $urandom_range(0, 25));
        if (roll < 44) return CH_COMMA;
        if (roll < 52) return CH_LPAREN;
        if (roll < 58) return CH_LBRACE;
        if (roll < 66)
        begin
            if (open_lvl == 0 && $urandom_range(0, 3) != 0)
                return BYTE_W'("a" + $urandom_range(0, 25));
            return ($urandom_range(0, 1) == 0) ? CH_RPAREN : CH_RBRACE;
        end
        if (roll < 73) return CH_QUOTE;
        if (roll < 78) return CH_BACKSLASH;
        if (roll < 81) return CH_HASH;
        if (roll < 85) return CH_NEWLINE;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Receiver: switch between stall patterns at random, and serve each hold
    // request from the sender with one long stretch of ready low.
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       holds_served;
        int       tick;
        mode         = RX_OPEN;
        mode_left    = 0;
        holds_served = 0;
        tick         = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                RX_OPEN:    result_ready <= 1'b1;
                RX_COIN:    result_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE:  result_ready <= ($urandom_range(0, 3) == 0);
                RX_CADENCE: result_ready <= (tick % 3 != 0);
                default:    result_ready <= 1'b1;
            endcase
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((text_valid && text_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles (%0d bytes in, %0d out)",
                 quiet, bytes_in, bytes_out);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int               rand_start;
        int               len;
        int               open_lvl;
        bit               paused;
        logic [BYTE_W-1:0] c;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lists. Extremes of the byte range, then a plain split.
        offer(8'h00, 1'b0);
        offer(8'hFF, 1'b0);
        send_list("a,b");
        // Commas inside brackets stay in the piece; a comma as the last byte
        // still splits and closes the empty piece behind it.
        send_list("({,}),,");
        // Escaped quote inside a string, comma in the string, a comment that
        // swallows a comma, then a newline ending the comment.
        send_list("\"\\\",\"#,\n,");
        // Unbalanced close wraps the depth: no split until the open brings it
        // back to zero.
        send_list("),(,");
        wait_all_back();

        // Back-pressure: ask for a long receiver hold while streaming a list
        // with no gaps, so the block fills and drops text_ready.
        hold_requests <= hold_requests + 1;
        steady = 1'b1;
        send_list("{k,(m,n)},p,\"q,r\",s#t,u\n,v,w");
        wait_all_back();
        steady = 1'b0;

        // Random lists; pause once midway until every result is back.
        rand_start = beats_sent;
        paused     = 1'b0;
        while (beats_sent - rand_start < RANDOM_BEATS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            open_lvl = 0;
            for (int k = 0; k < len; k++)
            begin
                c = pick_char(open_lvl);
                case (c)
                    CH_LPAREN, CH_LBRACE: open_lvl++;
                    CH_RPAREN, CH_RBRACE: if (open_lvl > 0) open_lvl--;
                    default: ;
                endcase
                offer(c, k == len - 1);
            end
            if (!paused && beats_sent - rand_start >= RANDOM_BEATS / 2)
            begin
                paused = 1'b1;
                wait_all_back();
            end
        end

        // Let everything drain, then give a few spare cycles for stray beats.
        wait_all_back();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d bytes in %0d lists with %0d splitting commas",
                 bytes_in, lists_closed, splits_seen);
        $display("results checked: %0d, mismatches: %0d", bytes_out, mismatches);
        if (mismatches == 0 && bytes_in == bytes_out)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* nesting_aware_comma_splitter.f */
src/nacs_pkg.sv
src/nacs_scan.sv
src/nesting_aware_comma_splitter.sv
src/nacs_checker.sv
tb/nacs_split_checker.sv
tb/nesting_aware_comma_splitter_tb.sv
